>>> rtl/core/address_alias_table_defines.svh
// Assertion helpers shared by the block.
`ifndef ADDRESS_ALIAS_TABLE_DEFINES_SVH
`define ADDRESS_ALIAS_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define AAT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define AAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/aat_pkg.sv
package aat_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SLOT_OUT_W = 8;
  localparam int HASH_W     = 32;
  localparam int ADDR_W     = 32;
  localparam int PAIR_W     = 16;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  localparam logic [7:0] OCTET_ALIAS = 8'hFF;
  localparam logic [7:0] FIRST_RST   = 8'd7;
  localparam logic [7:0] SECOND_RST  = 8'd8;
  localparam logic [7:0] FIRST_STEP  = 8'd3;
  localparam logic [7:0] SECOND_STEP = 8'd1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_HASH   = 2'd1,
    OP_ADDR   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [HASH_W-1:0] hash;
    logic [PAIR_W-1:0] pair;
  } st_wr_t;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [PAIR_W-1:0] pair;
  } st_rd_t;

  // 255.a.b.(a+b), first octet in the low byte
  function automatic logic [ADDR_W-1:0] alias_of(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] s;
    s = a + b;
    return {s, b, a, OCTET_ALIAS};
  endfunction

endpackage

>>> rtl/core/aat_in_if.sv
interface aat_in_if;
  logic                         valid;
  logic                         ready;
  aat_pkg::op_t                 operation;
  logic [aat_pkg::HASH_W-1:0]   key_hash;
  logic [aat_pkg::ADDR_W-1:0]   query_address;

  modport source (output valid, output operation, output key_hash, output query_address,
                  input ready);
  modport sink   (input valid, input operation, input key_hash, input query_address,
                  output ready);
endinterface

>>> rtl/core/aat_out_if.sv
interface aat_out_if;
  logic                             valid;
  logic                             ready;
  logic [aat_pkg::ADDR_W-1:0]       alias_address;
  logic                             hit;
  logic [aat_pkg::SLOT_OUT_W-1:0]   slot;
  logic                             looks_alias;

  modport source (output valid, output alias_address, output hit, output slot,
                  output looks_alias, input ready);
  modport sink   (input valid, input alias_address, input hit, input slot,
                  input looks_alias, output ready);
endinterface

>>> rtl/core/address_alias_table.sv
// Address alias table.
// in_if carries one request: operation, key_hash, query_address. It is
// taken when valid and ready are both high; ready is high only while the
// sequencer is idle, so one request is in work at a time.
// out_if returns exactly one result per request: alias_address, hit, slot,
// looks_alias, held in an output register until the sink takes it.
// Insert and clear go straight from the request to the result state.
// Lookups scan the ring one slot per cycle through a single comparator and
// a registered read of the slot memory, stopping at the first valid match.
// Back-to-back lookups: a new request is taken only after the previous
// one has left the sequencer.
// A new request may be taken while the previous result still waits on
// out_if; if the sink stalls, the finished result waits in the sequencer and
// no further request is taken until the output register frees.
// Reset (synchronous, rst_n low) invalidates every slot, sets the write
// pointer to 0 and the alias pair to 7, 8, and drops any pending result.
`include "address_alias_table_defines.svh"

module address_alias_table (
  input  logic       clk,
  input  logic       rst_n,
  aat_in_if.sink     in_if,
  aat_out_if.source  out_if
);

  aat_pkg::state_t               state_r, state_nxt;
  aat_pkg::op_t                  op_r, op_nxt;
  logic [aat_pkg::HASH_W-1:0]    key_r, key_nxt;
  logic                          looks_r, looks_nxt;
  logic [aat_pkg::SLOT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [aat_pkg::SLOT_W-1:0]    scan_inc;
  logic [aat_pkg::SLOT_W-1:0]    wp_r, wp_nxt;
  logic [7:0]                    first_r, first_nxt;
  logic [7:0]                    second_r, second_nxt;
  logic [aat_pkg::ADDR_W-1:0]    res_alias_r, res_alias_nxt;
  logic                          res_hit_r, res_hit_nxt;
  logic [aat_pkg::SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [aat_pkg::ADDR_W-1:0]    out_alias_r, out_alias_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [aat_pkg::SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic                          out_looks_r, out_looks_nxt;

  logic                          in_ready;
  logic                          accept;
  logic                          out_free;
  logic [aat_pkg::HASH_W-1:0]    cmp_operand;
  logic                          match;
  logic [7:0]                    o2, o3, o4;
  logic [8:0]                    octet_sum;

  aat_pkg::st_wr_t               st_wr;
  logic                          st_clr;
  logic [aat_pkg::SLOT_W-1:0]    st_rd_addr;
  aat_pkg::st_rd_t               st_rd;

  aat_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (st_wr),
    .clr     (st_clr),
    .rd_addr (st_rd_addr),
    .rd      (st_rd)
  );

  assign in_ready = (state_r == aat_pkg::S_IDLE);
  assign accept   = in_if.valid && in_ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign scan_inc = scan_idx_r + aat_pkg::SLOT_W'(1);

  assign o2        = in_if.query_address[15:8];
  assign o3        = in_if.query_address[23:16];
  assign o4        = in_if.query_address[31:24];
  assign octet_sum = {1'b0, o2} + {1'b0, o3};

  // shared comparator: hash key or zero-extended pair
  assign cmp_operand = (op_r == aat_pkg::OP_HASH) ? st_rd.hash
                                                  : {{(aat_pkg::HASH_W-aat_pkg::PAIR_W){1'b0}},
                                                     st_rd.pair};
  assign match = st_rd.valid && (cmp_operand == key_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    looks_nxt     = looks_r;
    scan_idx_nxt  = scan_idx_r;
    wp_nxt        = wp_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    res_alias_nxt = res_alias_r;
    res_hit_nxt   = res_hit_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_alias_nxt = out_alias_r;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    out_looks_nxt = out_looks_r;
    st_wr         = '0;
    st_clr        = 1'b0;
    st_rd_addr    = scan_inc;

    case (state_r)
      aat_pkg::S_IDLE: begin
        st_rd_addr = '0;
        if (accept) begin
          op_nxt        = in_if.operation;
          res_alias_nxt = '0;
          res_hit_nxt   = 1'b0;
          res_slot_nxt  = '0;
          looks_nxt     = 1'b0;
          scan_idx_nxt  = '0;
          case (in_if.operation)
            aat_pkg::OP_INSERT: begin
              st_wr.en      = 1'b1;
              st_wr.addr    = wp_r;
              st_wr.hash    = in_if.key_hash;
              st_wr.pair    = {second_r, first_r};
              res_alias_nxt = aat_pkg::alias_of(first_r, second_r);
              res_hit_nxt   = 1'b1;
              res_slot_nxt  = wp_r;
              first_nxt     = first_r + aat_pkg::FIRST_STEP;
              second_nxt    = second_r + aat_pkg::SECOND_STEP;
              wp_nxt        = (wp_r == aat_pkg::SLOT_LAST) ? '0 : wp_r + aat_pkg::SLOT_W'(1);
              state_nxt     = aat_pkg::S_RESULT;
            end
            aat_pkg::OP_HASH: begin
              key_nxt   = in_if.key_hash;
              state_nxt = aat_pkg::S_SCAN;
            end
            aat_pkg::OP_ADDR: begin
              key_nxt   = {{(aat_pkg::HASH_W-aat_pkg::PAIR_W){1'b0}},
                           in_if.query_address[23:8]};
              looks_nxt = (in_if.query_address[7:0] == aat_pkg::OCTET_ALIAS) &&
                          (octet_sum == {1'b0, o4});
              state_nxt = aat_pkg::S_SCAN;
            end
            aat_pkg::OP_CLEAR: begin
              st_clr    = 1'b1;
              state_nxt = aat_pkg::S_RESULT;
            end
            default: begin
              state_nxt = aat_pkg::S_RESULT;
            end
          endcase
        end
      end
      aat_pkg::S_SCAN: begin
        if (match) begin
          res_alias_nxt = aat_pkg::alias_of(st_rd.pair[7:0], st_rd.pair[15:8]);
          res_hit_nxt   = 1'b1;
          res_slot_nxt  = scan_idx_r;
          state_nxt     = aat_pkg::S_RESULT;
        end else if (scan_idx_r == aat_pkg::SLOT_LAST) begin
          state_nxt = aat_pkg::S_RESULT;
        end else begin
          scan_idx_nxt = scan_inc;
        end
      end
      aat_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_alias_nxt = res_alias_r;
          out_hit_nxt   = res_hit_r;
          out_slot_nxt  = aat_pkg::SLOT_OUT_W'(res_slot_r);
          out_looks_nxt = looks_r;
          state_nxt     = aat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = aat_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aat_pkg::S_IDLE;
      wp_r        <= '0;
      first_r     <= aat_pkg::FIRST_RST;
      second_r    <= aat_pkg::SECOND_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    looks_r     <= looks_nxt;
    scan_idx_r  <= scan_idx_nxt;
    res_alias_r <= res_alias_nxt;
    res_hit_r   <= res_hit_nxt;
    res_slot_r  <= res_slot_nxt;
    out_alias_r <= out_alias_nxt;
    out_hit_r   <= out_hit_nxt;
    out_slot_r  <= out_slot_nxt;
    out_looks_r <= out_looks_nxt;
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_r;
  assign out_if.alias_address = out_alias_r;
  assign out_if.hit           = out_hit_r;
  assign out_if.slot          = out_slot_r;
  assign out_if.looks_alias   = out_looks_r;

  `AAT_ASSERT_NEXT(a_lookup_scans,
    accept && (in_if.operation == aat_pkg::OP_HASH || in_if.operation == aat_pkg::OP_ADDR),
    state_r == aat_pkg::S_SCAN, "lookup request did not start a scan")
  `AAT_ASSERT_NEXT(a_insert_moves_wp, accept && in_if.operation == aat_pkg::OP_INSERT,
    wp_r != $past(wp_r), "insert did not advance the write pointer")
  `AAT_ASSERT_IMPLY(a_out_from_result, $rose(out_valid_r),
    $past(state_r) == aat_pkg::S_RESULT, "result loaded outside the result state")
  `AAT_ASSERT_IMPLY(a_miss_zero, out_valid_r && !out_hit_r,
    out_alias_r == '0 && out_slot_r == '0, "miss result carries alias or slot")

endmodule

>>> rtl/core/aat_store.sv
module aat_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  aat_pkg::st_wr_t                wr,
  input  logic                           clr,
  input  logic [aat_pkg::SLOT_W-1:0]     rd_addr,
  output aat_pkg::st_rd_t                rd
);

  logic [aat_pkg::HASH_W+aat_pkg::PAIR_W-1:0] slot_mem_r [aat_pkg::SLOTS];
  logic [aat_pkg::SLOTS-1:0] valid_r;
  logic [aat_pkg::SLOTS-1:0] valid_nxt;
  aat_pkg::st_rd_t           rd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (clr) begin
      valid_nxt = '0;
    end else if (wr.en) begin
      valid_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slot_mem_r[wr.addr] <= {wr.hash, wr.pair};
    end
    rd_r.valid          <= valid_r[rd_addr];
    {rd_r.hash, rd_r.pair} <= slot_mem_r[rd_addr];
  end

  assign rd = rd_r;

endmodule
